FILE: rtl/core/fpalu_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fpalu_pkg: shared definitions for the fixed-point arithmetic unit
// Command codes, result flags and default word geometry.
// ---------------------------------------------------------------------------
package fpalu_pkg;

  localparam int FRACTION_BITS_DEF = 8;
  localparam int WORD_WIDTH_DEF    = 32;
  localparam int CMD_W             = 4;
  localparam int IO_W              = 32;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD      = 4'd0,
    CMD_SUB      = 4'd1,
    CMD_MUL      = 4'd2,
    CMD_DIV      = 4'd3,
    CMD_INC      = 4'd4,
    CMD_DEC      = 4'd5,
    CMD_CMP      = 4'd6,
    CMD_MIN      = 4'd7,
    CMD_MAX      = 4'd8,
    CMD_TO_INT   = 4'd9,
    CMD_FROM_INT = 4'd10
  } cmd_t;

  // Result flags carried down the pipe
  typedef struct packed {
    logic lt;
    logic eq;
    logic gt;
    logic ovf;
    logic dz;
  } flags_t;

endpackage

FILE: rtl/core/fpalu_div_stage.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fpalu_div_stage: one restoring-division step with a pipeline register
// Shifts one numerator bit into the partial remainder and records one
// quotient bit. Holds its outputs while the pipe stalls.
// ---------------------------------------------------------------------------
module fpalu_div_stage #(
  parameter int NW = 40,
  parameter int DW = 32,
  parameter int BIT = 0
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num_in,
  input  logic [DW:0]   rem_in,
  input  logic [NW-1:0] quo_in,
  input  logic [DW-1:0] den_in,
  output logic [NW-1:0] num_out,
  output logic [DW:0]   rem_out,
  output logic [NW-1:0] quo_out,
  output logic [DW-1:0] den_out
);

  logic [DW+1:0] trial;
  logic [DW+1:0] sub;
  logic [DW:0]   rem_nxt;
  logic [NW-1:0] quo_nxt;

  // Compare-subtract for one quotient bit
  always_comb begin
    trial   = {rem_in, num_in[BIT]};
    sub     = trial - {2'b00, den_in};
    quo_nxt = quo_in;
    if (!sub[DW+1]) begin
      rem_nxt      = sub[DW:0];
      quo_nxt[BIT] = 1'b1;
    end else begin
      rem_nxt = trial[DW:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_out <= num_in;
      rem_out <= rem_nxt;
      quo_out <= quo_nxt;
      den_out <= den_in;
    end
  end

endmodule

FILE: rtl/core/fixed_point_alu.sv
`timescale 1ns / 1ps
// Every command travels the same pipe (one division step per stage sets the
// depth), so order is kept. Throughput: one item per cycle while the output
// register is not stalled by out_tready.
// Reset: rst_n (synchronous, active low) clears all valid bits; payload
// registers are not reset.
// ---------------------------------------------------------------------------
// fixed_point_alu: pipelined signed fixed-point arithmetic unit
// Decode, operate, divide steps, round and saturate, output register.
// ---------------------------------------------------------------------------
module fixed_point_alu
  import fpalu_pkg::*;
#(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF,
  parameter int WORD_WIDTH    = WORD_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // command[3:0], operand_a[35:4], operand_b[67:36], 0
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // result_value[31:0], is_less, is_equal,
                                  // is_greater, overflowed, divide_by_zero, 0
);

  localparam int W  = WORD_WIDTH;
  localparam int F  = FRACTION_BITS;
  localparam int NW = W + F;        // dividend width
  localparam int PW = 2 * W;        // product width
  localparam int DEPTH = NW + 4;

  // Stage payload between front and divider
  typedef struct packed {
    cmd_t          cmd;
    logic          neg;
    logic          bz;
    flags_t        fl;
    logic [W-1:0]  res;   // result for simple commands
    logic [PW:0]   prod;  // rounded product magnitude (pre shift)
  } pay_t;

  logic en;
  logic [DEPTH-1:0] vld_r;
  logic [DEPTH-1:0] vld_nxt;

  // Stall only when the output register is full and not taken
  assign en        = !(vld_r[DEPTH-1] && !out_tready);
  assign in_tready = en;
  assign out_tvalid = vld_r[DEPTH-1];

  always_comb begin
    vld_nxt = {vld_r[DEPTH-2:0], in_tvalid};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  // ---- stage 0: capture operands -------------------------------------------
  logic [CMD_W-1:0] cmd_in;
  logic [IO_W-1:0]  ai, bi;
  logic signed [W-1:0] a0, b0;
  assign cmd_in = in_tdata[3:0];
  assign ai     = in_tdata[35:4];
  assign bi     = in_tdata[67:36];

  always_comb begin
    if (W >= IO_W) begin
      a0 = W'($signed(ai));
      b0 = W'($signed(bi));
    end else begin
      a0 = ai[W-1:0];
      b0 = bi[W-1:0];
    end
  end

  cmd_t cmd1_r;
  logic signed [W-1:0] a1_r, b1_r;
  always_ff @(posedge clk) begin
    if (en) begin
      cmd1_r <= cmd_t'(cmd_in);
      a1_r   <= a0;
      b1_r   <= b0;
    end
  end

  // ---- stage 1: simple ops, compare, magnitudes ----------------------------
  localparam logic signed [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

  logic [W-1:0] ma, mb;
  logic signed [W:0] sum, dif;
  logic [W-1:0] sres;
  logic sovf;
  logic lt, eq, gt;
  logic [W:0] ash;
  always_comb begin
    ma  = a1_r[W-1] ? W'(-a1_r) : a1_r;
    mb  = b1_r[W-1] ? W'(-b1_r) : b1_r;
    lt  = a1_r < b1_r;
    eq  = a1_r == b1_r;
    gt  = a1_r > b1_r;
    sum = {a1_r[W-1], a1_r} + {b1_r[W-1], b1_r};
    dif = {a1_r[W-1], a1_r} - {b1_r[W-1], b1_r};
    ash = $signed({a1_r[W-1], a1_r}) >>> F;
    sres = '0;
    sovf = 1'b0;
    case (cmd1_r)
      CMD_ADD: begin
        if (sum[W] != sum[W-1]) begin
          sovf = 1'b1;
          sres = sum[W] ? MINV : MAXV;
        end else sres = sum[W-1:0];
      end
      CMD_SUB: begin
        if (dif[W] != dif[W-1]) begin
          sovf = 1'b1;
          sres = dif[W] ? MINV : MAXV;
        end else sres = dif[W-1:0];
      end
      CMD_INC: begin
        if (a1_r == MAXV) begin sovf = 1'b1; sres = MAXV; end
        else sres = W'(a1_r + 1'b1);
      end
      CMD_DEC: begin
        if (a1_r == MINV) begin sovf = 1'b1; sres = MINV; end
        else sres = W'(a1_r - 1'b1);
      end
      CMD_MIN:    sres = lt ? a1_r : b1_r;
      CMD_MAX:    sres = gt ? a1_r : b1_r;
      CMD_TO_INT: sres = ash[W-1:0];
      default:    sres = '0;
    endcase
  end

  // FROM_INT takes its sign from operand_a alone
  pay_t p2_r;
  logic [W-1:0] ma2_r, mb2_r;
  always_ff @(posedge clk) begin
    if (en) begin
      p2_r.cmd  <= cmd1_r;
      p2_r.neg  <= (cmd1_r == CMD_FROM_INT) ? a1_r[W-1] : (a1_r[W-1] ^ b1_r[W-1]);
      p2_r.bz   <= (b1_r == '0);
      p2_r.fl   <= '{lt: lt, eq: eq, gt: gt, ovf: sovf, dz: 1'b0};
      p2_r.res  <= sres;
      p2_r.prod <= '0;
      ma2_r     <= ma;
      mb2_r     <= mb;
    end
  end

  // ---- stage 2: product (single registered multiply) ------------------------
  pay_t p3_nxt;
  always_comb begin
    p3_nxt      = p2_r;
    p3_nxt.prod = {1'b0, PW'(ma2_r) * PW'(mb2_r)} + ((PW+1)'(1) << (F - 1));
  end

  pay_t p3_r;
  logic [NW-1:0] num3_r;
  logic [W-1:0]  den3_r;
  always_ff @(posedge clk) begin
    if (en) begin
      p3_r      <= p3_nxt;
      num3_r    <= NW'(ma2_r) << F;
      den3_r    <= (p2_r.bz ? W'(1) : mb2_r);
    end
  end

  // ---- division steps, one quotient bit per stage ---------------------------
  logic [NW-1:0] num_s [NW+1];
  logic [W:0]    rem_s [NW+1];
  logic [NW-1:0] quo_s [NW+1];
  logic [W-1:0]  den_s [NW+1];
  pay_t          pay_s [NW+1];

  assign num_s[0] = num3_r;
  assign rem_s[0] = '0;
  assign quo_s[0] = '0;
  assign den_s[0] = den3_r;
  assign pay_s[0] = p3_r;

  for (genvar i = 0; i < NW; i++) begin : g_div
    fpalu_div_stage #(.NW(NW), .DW(W), .BIT(NW-1-i)) u_step (
      .clk     (clk),
      .en      (en),
      .num_in  (num_s[i]),
      .rem_in  (rem_s[i]),
      .quo_in  (quo_s[i]),
      .den_in  (den_s[i]),
      .num_out (num_s[i+1]),
      .rem_out (rem_s[i+1]),
      .quo_out (quo_s[i+1]),
      .den_out (den_s[i+1])
    );
    always_ff @(posedge clk) begin
      if (en) begin
        pay_s[i+1] <= pay_s[i];
      end
    end
  end

  // ---- final stage: round, sign, saturate ----------------------------------
  pay_t pf;
  logic [W:0] remf;
  logic [W-1:0] denf;
  logic [NW-1:0] qf;
  logic [PW+1:0] mag;
  logic [W-1:0] fres;
  logic fovf;
  logic [W:0] lim;
  logic [PW:0] pshift;
  always_comb begin
    pf   = pay_s[NW];
    remf = rem_s[NW];
    denf = den_s[NW];
    qf   = quo_s[NW];
    lim  = pf.neg ? {2'b01, {(W-1){1'b0}}} : {2'b00, {(W-1){1'b1}}};
    pshift = pf.prod >> F;
    mag  = '0;
    case (pf.cmd)
      CMD_MUL: mag = (PW+2)'(pshift);
      CMD_DIV: mag = (PW+2)'(qf) + ((remf >= ((W+1)'(denf) - remf)) ? 1'b1 : 1'b0);
      CMD_FROM_INT: mag = (PW+2)'(num_s[NW]);
      default: mag = '0;
    endcase
    fres = pf.res;
    fovf = pf.fl.ovf;
    if (pf.cmd == CMD_MUL || pf.cmd == CMD_DIV || pf.cmd == CMD_FROM_INT) begin
      if (mag > (PW+2)'(lim)) begin
        fovf = 1'b1;
        mag  = (PW+2)'(lim);
      end
      fres = pf.neg ? W'(-mag) : mag[W-1:0];
    end
    if (pf.cmd == CMD_DIV && pf.bz) begin
      fres = '0;
      fovf = 1'b0;
    end
  end

  // Output register
  logic [W-1:0] res_r;
  flags_t fl_r;
  always_ff @(posedge clk) begin
    if (en) begin
      res_r  <= fres;
      fl_r   <= '{lt: pf.fl.lt, eq: pf.fl.eq, gt: pf.fl.gt, ovf: fovf,
                  dz: (pf.cmd == CMD_DIV) && pf.bz};
    end
  end

  logic [IO_W-1:0] res_io;
  always_comb begin
    if (W >= IO_W) res_io = res_r[IO_W-1:0];
    else res_io = IO_W'(res_r);
  end

  assign out_tdata = {3'b000, fl_r.dz, fl_r.ovf, fl_r.gt, fl_r.eq, fl_r.lt, res_io};

endmodule
